// ===== design/sorted_timer_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted timer queue assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTH
`define STQ_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define STQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define STQ_ASSERT_NOW(label, clk, rst_n, a, c)
`define STQ_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== design/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Codes, state type and shared structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package stq_pkg;

	localparam logic [2:0] MODE_ALLOC = 3'd0;
	localparam logic [2:0] MODE_FREE  = 3'd1;
	localparam logic [2:0] MODE_BIND  = 3'd2;
	localparam logic [2:0] MODE_ARM   = 3'd3;
	localparam logic [2:0] MODE_TICK  = 3'd4;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FAIL   = 2'd1;
	localparam logic [1:0] KIND_EXPIRY = 2'd2;
	localparam logic [1:0] KIND_SWITCH = 2'd3;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_ARMED = 2'd2;

	localparam logic [5:0] SWITCH_NONE = 6'd32;
	localparam logic [4:0] PROC_LIMIT  = 5'd31;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_ARM_ADD,
		S_ARM_WR,
		S_ARM_CHK,
		S_ARM_FIX,
		S_TK_INC,
		S_TK_CMP,
		S_TK_CHK,
		S_TK_FLUSH
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [4:0]  timer;
		logic [2:0]  queue;
		logic [31:0] tag;
		logic        last;
	} res_t;

	typedef struct packed {
		logic rd_en;
		logic dl_we;
		logic link_we;
		logic bind_we;
	} mem_ctl_t;

endpackage

// ===== design/stq_mem.sv =====
// ----------------------------------------------------------------------------
// Timer entry memory
// Deadline, link, queue and tag per entry; one write address, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stq_mem #(
	parameter int TIMER_COUNT = 32,
	parameter int IW = 5
) (
	input  logic             clk,
	input  stq_pkg::mem_ctl_t ctl,
	input  logic [IW-1:0]    rd_addr,
	input  logic [IW-1:0]    wr_addr,
	input  logic [31:0]      dl_wdata,
	input  logic [IW-1:0]    link_wdata,
	input  logic [2:0]       q_wdata,
	input  logic [31:0]      tag_wdata,
	output logic [31:0]      dl_rd,
	output logic [IW-1:0]    link_rd,
	output logic [2:0]       q_rd,
	output logic [31:0]      tag_rd
);
	logic [31:0]   dl_mem   [TIMER_COUNT];
	logic [IW-1:0] link_mem [TIMER_COUNT];
	logic [2:0]    q_mem    [TIMER_COUNT];
	logic [31:0]   tag_mem  [TIMER_COUNT];

	always_ff @(posedge clk) begin
		if (ctl.dl_we) begin
			dl_mem[wr_addr] <= dl_wdata;
		end
		if (ctl.link_we) begin
			link_mem[wr_addr] <= link_wdata;
		end
		if (ctl.bind_we) begin
			q_mem[wr_addr]   <= q_wdata;
			tag_mem[wr_addr] <= tag_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			dl_rd   <= dl_mem[rd_addr];
			link_rd <= link_mem[rd_addr];
			q_rd    <= q_mem[rd_addr];
			tag_rd  <= tag_mem[rd_addr];
		end
	end

endmodule

// ===== design/stq_seq.sv =====
// ----------------------------------------------------------------------------
// Timer queue sequencer
// Entry status, list walk for arm and tick, allocation scan, result staging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_timer_queue_macros.svh"
module stq_seq #(
	parameter int TIMER_COUNT = 32,
	parameter int QUEUE_COUNT = 8,
	parameter int IW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        mode,
	input  logic [4:0]        timer_id,
	input  logic [2:0]        queue_id,
	input  logic [31:0]       interval,
	input  logic [5:0]        switch_timer,
	input  logic              res_free,
	output stq_pkg::res_t     res,
	output stq_pkg::mem_ctl_t ctl,
	output logic [IW-1:0]     rd_addr,
	output logic [IW-1:0]     wr_addr,
	output logic [31:0]       dl_wdata,
	output logic [IW-1:0]     link_wdata,
	input  logic [31:0]       dl_rd,
	input  logic [IW-1:0]     link_rd,
	input  logic [2:0]        q_rd_in,
	input  logic [31:0]       tag_rd_in
);
	localparam int AN = (TIMER_COUNT < 32) ? TIMER_COUNT : 32;
	localparam logic [IW-1:0] SCAN_LAST = IW'(AN - 1);

	stq_pkg::state_t state_q, state_d;
	logic [1:0]    status_q [TIMER_COUNT];
	logic [IW-1:0] id_q, head_q, cur_q, prev_q, scan_q;
	logic [31:0]   iv_q, tick_q, next_dl_q, dl_q;
	logic          at_head_q, ts_q, pend_v_q;
	logic [4:0]    proc_q;
	logic [4:0]    pend_timer_q;
	logic [2:0]    pend_queue_q;
	logic [31:0]   pend_tag_q;

	logic [5:0]    id6, cur6, scan6;
	logic [IW-1:0] id_in, link_nx;
	logic          id_ok, accept, due, is_sw, tk_adv, hit;
	logic [31:0]   dl_eff;

	assign id6    = {1'b0, timer_id};
	assign id_in  = id6[IW-1:0];
	assign id_ok  = id6 < 6'(TIMER_COUNT);
	assign cur6   = 6'(cur_q);
	assign scan6  = 6'(scan_q);
	assign accept = in_valid && in_ready;
	// sentinel deadline is fixed at all ones
	assign dl_eff = (cur_q == '0) ? 32'hffff_ffff : dl_rd;
	assign link_nx = ({1'b0, link_rd} < (IW+1)'(TIMER_COUNT)) ? link_rd : '0;
	assign due    = (cur_q != '0) && (proc_q != stq_pkg::PROC_LIMIT) && (dl_eff <= tick_q);
	assign is_sw  = (cur6 == switch_timer);
	assign tk_adv = due && (is_sw || !pend_v_q || res_free);
	assign hit    = dl_q <= dl_eff;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		res        = '0;
		ctl        = '0;
		rd_addr    = cur_q;
		wr_addr    = id_q;
		dl_wdata   = dl_q;
		link_wdata = cur_q;
		case (state_q)
			stq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				wr_addr  = id_in;
				if (in_valid) begin
					case (mode)
						stq_pkg::MODE_ALLOC: state_d = stq_pkg::S_ALLOC;
						stq_pkg::MODE_BIND: begin
							ctl.bind_we = id_ok && ({6'd0, queue_id} < 9'(QUEUE_COUNT));
						end
						stq_pkg::MODE_ARM: begin
							if (id_ok && status_q[id_in] != stq_pkg::ST_ARMED) begin
								state_d = stq_pkg::S_ARM_ADD;
							end
						end
						stq_pkg::MODE_TICK: state_d = stq_pkg::S_TK_INC;
						default: ;
					endcase
				end
			end
			stq_pkg::S_ALLOC: begin
				if (status_q[scan_q] == stq_pkg::ST_FREE) begin
					if (res_free) begin
						res.valid = 1'b1;
						res.kind  = stq_pkg::KIND_ALLOC;
						res.timer = scan6[4:0];
						res.last  = 1'b1;
						state_d   = stq_pkg::S_IDLE;
					end
				end else if (scan_q == SCAN_LAST) begin
					if (res_free) begin
						res.valid = 1'b1;
						res.kind  = stq_pkg::KIND_FAIL;
						res.last  = 1'b1;
						state_d   = stq_pkg::S_IDLE;
					end
				end
			end
			stq_pkg::S_ARM_ADD: state_d = stq_pkg::S_ARM_WR;
			stq_pkg::S_ARM_WR: begin
				ctl.dl_we = 1'b1;
				ctl.rd_en = 1'b1;
				rd_addr   = head_q;
				state_d   = stq_pkg::S_ARM_CHK;
			end
			stq_pkg::S_ARM_CHK: begin
				if (hit) begin
					ctl.link_we = 1'b1;
					if (at_head_q) begin
						state_d = stq_pkg::S_IDLE;
					end else begin
						wr_addr    = prev_q;
						link_wdata = id_q;
						state_d    = stq_pkg::S_ARM_FIX;
					end
				end else begin
					ctl.rd_en = 1'b1;
					rd_addr   = link_nx;
				end
			end
			stq_pkg::S_ARM_FIX: begin
				ctl.link_we = 1'b1;
				state_d     = stq_pkg::S_IDLE;
			end
			stq_pkg::S_TK_INC: state_d = stq_pkg::S_TK_CMP;
			stq_pkg::S_TK_CMP: begin
				if (next_dl_q > tick_q) begin
					state_d = stq_pkg::S_IDLE;
				end else begin
					ctl.rd_en = 1'b1;
					rd_addr   = head_q;
					state_d   = stq_pkg::S_TK_CHK;
				end
			end
			stq_pkg::S_TK_CHK: begin
				if (due) begin
					if (tk_adv) begin
						ctl.rd_en = 1'b1;
						rd_addr   = link_nx;
					end
					// push the staged event out once a newer one replaces it
					if (!is_sw && pend_v_q && res_free) begin
						res.valid = 1'b1;
						res.kind  = stq_pkg::KIND_EXPIRY;
						res.timer = pend_timer_q;
						res.queue = pend_queue_q;
						res.tag   = pend_tag_q;
					end
				end else begin
					state_d = stq_pkg::S_TK_FLUSH;
				end
			end
			stq_pkg::S_TK_FLUSH: begin
				if (pend_v_q) begin
					if (res_free) begin
						res.valid = 1'b1;
						res.kind  = stq_pkg::KIND_EXPIRY;
						res.timer = pend_timer_q;
						res.queue = pend_queue_q;
						res.tag   = pend_tag_q;
						res.last  = !ts_q;
					end
				end else if (ts_q) begin
					if (res_free) begin
						res.valid = 1'b1;
						res.kind  = stq_pkg::KIND_SWITCH;
						res.timer = switch_timer[4:0];
						res.last  = 1'b1;
					end
				end else begin
					state_d = stq_pkg::S_IDLE;
				end
			end
			default: state_d = stq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				status_q[i] <= (i == 0) ? stq_pkg::ST_ARMED : stq_pkg::ST_FREE;
			end
			tick_q    <= '0;
			next_dl_q <= 32'hffff_ffff;
			head_q    <= '0;
			pend_v_q  <= 1'b0;
			ts_q      <= 1'b0;
		end else begin
			case (state_q)
				stq_pkg::S_IDLE: begin
					if (accept && mode == stq_pkg::MODE_FREE && id_ok &&
					    status_q[id_in] != stq_pkg::ST_ARMED) begin
						status_q[id_in] <= stq_pkg::ST_FREE;
					end
				end
				stq_pkg::S_ALLOC: begin
					if (status_q[scan_q] == stq_pkg::ST_FREE && res_free) begin
						status_q[scan_q] <= stq_pkg::ST_ALLOC;
					end
				end
				stq_pkg::S_ARM_ADD: status_q[id_q] <= stq_pkg::ST_ARMED;
				stq_pkg::S_ARM_CHK: begin
					if (hit && at_head_q) begin
						head_q    <= id_q;
						next_dl_q <= dl_q;
					end
				end
				stq_pkg::S_TK_INC: tick_q <= tick_q + 32'd1;
				stq_pkg::S_TK_CMP: begin
					ts_q     <= 1'b0;
					pend_v_q <= 1'b0;
				end
				stq_pkg::S_TK_CHK: begin
					if (tk_adv) begin
						status_q[cur_q] <= stq_pkg::ST_ALLOC;
						if (is_sw) begin
							ts_q <= 1'b1;
						end else begin
							pend_v_q <= 1'b1;
						end
					end else if (!due) begin
						head_q    <= cur_q;
						next_dl_q <= dl_eff;
					end
				end
				stq_pkg::S_TK_FLUSH: begin
					if (res_free) begin
						if (pend_v_q) begin
							pend_v_q <= 1'b0;
						end else begin
							ts_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= id_in;
			iv_q   <= interval;
			scan_q <= '0;
		end
		if (state_q == stq_pkg::S_ALLOC && status_q[scan_q] != stq_pkg::ST_FREE &&
		    scan_q != SCAN_LAST) begin
			scan_q <= scan_q + 1'b1;
		end
		if (state_q == stq_pkg::S_ARM_ADD) begin
			dl_q <= iv_q + tick_q;
		end
		if (state_q == stq_pkg::S_ARM_WR) begin
			cur_q     <= head_q;
			at_head_q <= 1'b1;
		end
		if (state_q == stq_pkg::S_ARM_CHK && !hit) begin
			prev_q    <= cur_q;
			cur_q     <= link_nx;
			at_head_q <= 1'b0;
		end
		if (state_q == stq_pkg::S_TK_CMP) begin
			cur_q  <= head_q;
			proc_q <= '0;
		end
		if (state_q == stq_pkg::S_TK_CHK && tk_adv) begin
			cur_q  <= link_nx;
			proc_q <= proc_q + 5'd1;
			if (!is_sw) begin
				// queue and tag of the entry under the walk come from the read port
				pend_timer_q <= cur6[4:0];
				pend_queue_q <= q_rd_in;
				pend_tag_q   <= tag_rd_in;
			end
		end
	end

	`STQ_ASSERT_NOW(a_sentinel_armed, clk, arst_n, 1'b1, status_q[0] == stq_pkg::ST_ARMED)
	`STQ_ASSERT_NOW(a_res_room, clk, arst_n, res.valid, res_free)
	`STQ_ASSERT_NOW(a_res_state, clk, arst_n, res.valid,
		state_q == stq_pkg::S_ALLOC || state_q == stq_pkg::S_TK_CHK ||
		state_q == stq_pkg::S_TK_FLUSH)
	`STQ_ASSERT_NOW(a_head_armed, clk, arst_n, state_q == stq_pkg::S_IDLE,
		status_q[head_q] == stq_pkg::ST_ARMED)

endmodule

// ===== design/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue
// Timer pool on a deadline-sorted linked list with streaming command/result.
// ----------------------------------------------------------------------------
// Commands enter on s_*: s_tuser is the mode, s_tdata the operands. Results
// leave on m_*: m_tuser is the result kind, m_tlast marks the final result of
// a command. cfg_we/cfg_wdata set the task-switch timer (32 = none).
// One command at a time: s_tready is high only while the sequencer is idle.
// Free and bind complete in the idle state; allocate scans the status
// flags, one entry per cycle, arm walks the list to the insertion point,
// and tick walks the expired entries from the head, with the task switch
// result after other events; the walk is set by the single memory read
// port it reuses each step. Results go through a one-deep output register;
// a command is taken while its predecessor's last result still waits there.
// When m_tready is low the walk holds until the register frees up.
// Reset clears the count, empties the list down to the sentinel entry 0 and
// marks all other entries free; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sorted_timer_queue #(
	parameter int TIMER_COUNT = 32,
	parameter int QUEUE_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // timer_id[4:0], queue_id[7:5], tag[39:8], interval[71:40]
	input  logic [2:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_timer[4:0], out_queue[7:5], out_tag[39:8]
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);
	localparam int IW = $clog2(TIMER_COUNT);

	logic [5:0]        switch_q;
	logic              res_free;
	stq_pkg::res_t     res;
	stq_pkg::mem_ctl_t ctl;
	logic [IW-1:0]     rd_addr, wr_addr, link_wdata, link_rd;
	logic [31:0]       dl_wdata, dl_rd, tag_rd;
	logic [2:0]        q_rd;
	logic [39:0]       out_data_q;
	logic [1:0]        out_kind_q;
	logic              out_last_q, out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_q <= stq_pkg::SWITCH_NONE;
		end else if (cfg_we) begin
			switch_q <= cfg_wdata;
		end
	end

	assign res_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res.valid) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q <= {res.tag, res.queue, res.timer};
			out_kind_q <= res.kind;
			out_last_q <= res.last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	stq_seq #(
		.TIMER_COUNT(TIMER_COUNT),
		.QUEUE_COUNT(QUEUE_COUNT),
		.IW(IW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.mode        (s_tuser),
		.timer_id    (s_tdata[4:0]),
		.queue_id    (s_tdata[7:5]),
		.interval    (s_tdata[71:40]),
		.switch_timer(switch_q),
		.res_free    (res_free),
		.res         (res),
		.ctl         (ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.dl_wdata    (dl_wdata),
		.link_wdata  (link_wdata),
		.dl_rd       (dl_rd),
		.link_rd     (link_rd),
		.q_rd_in     (q_rd),
		.tag_rd_in   (tag_rd)
	);

	stq_mem #(
		.TIMER_COUNT(TIMER_COUNT),
		.IW(IW)
	) u_mem (
		.clk       (clk),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.dl_wdata  (dl_wdata),
		.link_wdata(link_wdata),
		.q_wdata   (s_tdata[7:5]),
		.tag_wdata (s_tdata[39:8]),
		.dl_rd     (dl_rd),
		.link_rd   (link_rd),
		.q_rd      (q_rd),
		.tag_rd    (tag_rd)
	);

endmodule
